[rtl/assert_macros.svh]
// Assertion macros shared by the RTL; compiled out when NO_ASSERTIONS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

[rtl/hidkb_pkg.sv]
// Package: ring sizing, key code constants and the US key map.
`timescale 1ns / 1ps
`default_nettype none

package hidkb_pkg;

   // Ring sizing; the ring keeps one slot free to tell full from empty
   localparam int QUEUE_DEPTH = 64;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CHAR_W      = 7;
   localparam int CNT_W       = 3;
   localparam int FILL_W      = 6;

   // Six key code slots in a boot report
   localparam int KEY_COUNT   = 6;
   localparam int KEY_IDX_W   = $clog2(KEY_COUNT);

   // Modifier bits for left and right shift
   localparam logic [7:0] SHIFT_MASK    = 8'h22;

   // Usage codes the translation skips outright
   localparam logic [7:0] CODE_NONE      = 8'h00;
   localparam logic [7:0] CODE_BACKSPACE = 8'h2A;
   localparam logic [7:0] CODE_SPACE     = 8'h2C;

   localparam logic [CHAR_W-1:0] ESC_CHAR = 7'h1B;

   // US layout lookup; zero means the code yields no character
   function automatic logic [CHAR_W-1:0] key_to_ascii(input logic [7:0] code,
                                                     input logic shift);
      logic [CHAR_W-1:0] plain;
      logic [CHAR_W-1:0] shifted;
      plain   = '0;
      shifted = '0;
      case (code) inside
         [8'h04:8'h1D]: begin
            // letters
            plain   = 7'(code - 8'h04) + 7'h61;
            shifted = 7'(code - 8'h04) + 7'h41;
         end
         [8'h1E:8'h26]: begin
            // digits 1..9, shifted symbols below
            plain = 7'(code - 8'h1E) + 7'h31;
            case (code)
               8'h1E:   shifted = 7'h21; // !
               8'h1F:   shifted = 7'h40; // @
               8'h20:   shifted = 7'h23; // #
               8'h21:   shifted = 7'h24; // $
               8'h22:   shifted = 7'h25; // %
               8'h23:   shifted = 7'h5E; // ^
               8'h24:   shifted = 7'h26; // &
               8'h25:   shifted = 7'h2A; // *
               default: shifted = 7'h28; // (
            endcase
         end
         8'h27: begin plain = 7'h30; shifted = 7'h29; end // 0 )
         8'h28: begin plain = 7'h0A; shifted = 7'h0A; end // enter
         8'h29: begin plain = ESC_CHAR; shifted = ESC_CHAR; end
         8'h2B: begin plain = 7'h09; shifted = 7'h09; end // tab
         8'h2D: begin plain = 7'h2D; shifted = 7'h5F; end // - _
         8'h2E: begin plain = 7'h3D; shifted = 7'h2B; end // = +
         8'h2F: begin plain = 7'h5B; shifted = 7'h7B; end // [ {
         8'h30: begin plain = 7'h5D; shifted = 7'h7D; end // ] }
         8'h31: begin plain = 7'h5C; shifted = 7'h7C; end // \ |
         8'h33: begin plain = 7'h3B; shifted = 7'h3A; end // ; :
         8'h34: begin plain = 7'h27; shifted = 7'h22; end // ' "
         8'h35: begin plain = 7'h60; shifted = 7'h7E; end // ` ~
         8'h36: begin plain = 7'h2C; shifted = 7'h3C; end // , <
         8'h37: begin plain = 7'h2E; shifted = 7'h3E; end // . >
         8'h38: begin plain = 7'h2F; shifted = 7'h3F; end // / ?
         default: begin plain = '0; shifted = '0; end
      endcase
      // backspace and space are dropped on purpose, as is key code zero
      if (code == CODE_NONE || code == CODE_BACKSPACE || code == CODE_SPACE) begin
         plain   = '0;
         shifted = '0;
      end
      return shift ? shifted : plain;
   endfunction

endpackage

`default_nettype wire

[rtl/hid_keyboard_report_to_ascii_fifo.sv]
// Top level: boot keyboard report translator feeding a character ring, with pops.
//
// Usage
//   Input: a command beat is taken when start is high and busy is low.
//   req_kind = 0 carries a boot report (modifiers and six key codes); each
//   key code is translated through the US map and pushed into a ring of
//   QUEUE_DEPTH - 1 characters, excess characters being dropped.
//   req_kind = 1 pops the oldest character, if any.
//   Output: every command gives one result beat, rsp_valid high for one
//   cycle; the receiver cannot hold it off.
//   Timing: a report walks its six key codes one per cycle, at most one ring
//   write each, with busy high while it walks, and the registered result
//   follows the last one. A read of a non-empty ring holds busy high in the
//   READ state for the ring RAM read; an empty read answers in the
//   cycle after the command with busy never raised.
//   Reset: synchronous; empties the ring (pointers to zero) and drops any
//   command in flight. Ring contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hid_keyboard_report_to_ascii_fifo (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output      logic                               busy,
   input  wire logic                               req_kind,
   input  wire logic [7:0]                         req_modifiers,
   input  wire logic [7:0]                         req_key_code_0,
   input  wire logic [7:0]                         req_key_code_1,
   input  wire logic [7:0]                         req_key_code_2,
   input  wire logic [7:0]                         req_key_code_3,
   input  wire logic [7:0]                         req_key_code_4,
   input  wire logic [7:0]                         req_key_code_5,
   output      logic                               rsp_valid,
   output      logic                               rsp_char_valid,
   output      logic [hidkb_pkg::CHAR_W-1:0]       rsp_char_code,
   output      logic [hidkb_pkg::CNT_W-1:0]        rsp_queued_count,
   output      logic [hidkb_pkg::CNT_W-1:0]        rsp_dropped_count,
   output      logic [hidkb_pkg::FILL_W-1:0]       rsp_fill_level
);

   localparam int PTR_W  = hidkb_pkg::PTR_W;
   localparam int CHAR_W = hidkb_pkg::CHAR_W;
   localparam int CNT_W  = hidkb_pkg::CNT_W;
   localparam int KEYS   = hidkb_pkg::KEY_COUNT;
   localparam int IDX_W  = hidkb_pkg::KEY_IDX_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_KEYS = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;

   localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(hidkb_pkg::QUEUE_DEPTH - 1);
   localparam logic [PTR_W:0]     DEPTH_X  = (PTR_W+1)'(hidkb_pkg::QUEUE_DEPTH);
   localparam logic [IDX_W-1:0]   IDX_LAST = IDX_W'(KEYS - 1);

   // control state
   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [PTR_W-1:0] rp_ff, rp_in;
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // payload
   logic [7:0]        keys_ff [0:KEYS-1];
   logic [7:0]        keys_in [0:KEYS-1];
   logic              shift_ff, shift_in;
   logic [CNT_W-1:0]  queued_ff, queued_in;
   logic [CNT_W-1:0]  dropped_ff, dropped_in;
   logic              char_valid_ff, char_valid_in;
   logic [CHAR_W-1:0] char_code_ff, char_code_in;
   logic [CNT_W-1:0]  rsp_queued_ff, rsp_queued_in;
   logic [CNT_W-1:0]  rsp_dropped_ff, rsp_dropped_in;
   logic [hidkb_pkg::FILL_W-1:0] fill_ff, fill_in;

   // ring RAM ports
   logic              wr_en;
   logic              rd_en;
   logic [CHAR_W-1:0] rd_data;
   logic [CHAR_W-1:0] key_char;
   logic [PTR_W-1:0]  wp_inc;
   logic [PTR_W-1:0]  rp_inc;
   logic              ring_full;
   logic              accept;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // pointer arithmetic, wrapping at the ring depth
   assign wp_inc    = (wp_ff == PTR_LAST) ? '0 : wp_ff + 1'b1;
   assign rp_inc    = (rp_ff == PTR_LAST) ? '0 : rp_ff + 1'b1;
   assign ring_full = (wp_inc == rp_ff);

   // key at the head of the shift line
   assign key_char = hidkb_pkg::key_to_ascii(keys_ff[0], shift_ff);
   assign wr_en    = (state_ff == ST_KEYS) && (key_char != '0) && !ring_full;
   assign rd_en    = accept && req_kind && (rp_ff != wp_ff);

   hidkb_ram #(
      .DEPTH (hidkb_pkg::QUEUE_DEPTH),
      .WIDTH (CHAR_W),
      .ADDR_W(PTR_W)
   ) u_ring (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wp_ff),
      .wr_data(key_char),
      .rd_en  (rd_en),
      .rd_addr(rp_ff),
      .rd_data(rd_data)
   );

   // ring occupancy from the pointers after this beat
   function automatic logic [hidkb_pkg::FILL_W-1:0] fill_of(input logic [PTR_W-1:0] wp,
                                                          input logic [PTR_W-1:0] rp);
      logic [PTR_W:0] diff;
      diff = (wp >= rp) ? {1'b0, wp} - {1'b0, rp} : {1'b0, wp} + DEPTH_X - {1'b0, rp};
      return hidkb_pkg::FILL_W'(diff);
   endfunction

   // sequencer
   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      rp_in          = rp_ff;
      wp_in          = wp_ff;
      shift_in       = shift_ff;
      queued_in      = queued_ff;
      dropped_in     = dropped_ff;
      rsp_valid_in   = 1'b0;
      char_valid_in  = char_valid_ff;
      char_code_in   = char_code_ff;
      rsp_queued_in  = rsp_queued_ff;
      rsp_dropped_in = rsp_dropped_ff;
      fill_in        = fill_ff;
      for (int i = 0; i < KEYS; i++) begin
         keys_in[i] = keys_ff[i];
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && !req_kind) begin
               keys_in[0] = req_key_code_0;
               keys_in[1] = req_key_code_1;
               keys_in[2] = req_key_code_2;
               keys_in[3] = req_key_code_3;
               keys_in[4] = req_key_code_4;
               keys_in[5] = req_key_code_5;
               shift_in   = (req_modifiers & hidkb_pkg::SHIFT_MASK) != '0;
               queued_in  = '0;
               dropped_in = '0;
               idx_in     = '0;
               state_in   = ST_KEYS;
            end else if (rd_en) begin
               state_in = ST_READ;
            end else if (accept) begin
               // read of an empty ring answers at once
               rsp_valid_in   = 1'b1;
               char_valid_in  = 1'b0;
               char_code_in   = '0;
               rsp_queued_in  = '0;
               rsp_dropped_in = '0;
               fill_in        = fill_of(wp_ff, rp_ff);
            end
         end
         ST_KEYS: begin
            // one key code per cycle, one ring write at most
            if (key_char != '0) begin
               if (ring_full) begin
                  dropped_in = dropped_ff + 1'b1;
               end else begin
                  queued_in = queued_ff + 1'b1;
                  wp_in     = wp_inc;
               end
            end
            for (int i = 0; i < KEYS - 1; i++) begin
               keys_in[i] = keys_ff[i+1];
            end
            keys_in[KEYS-1] = hidkb_pkg::CODE_NONE;
            idx_in          = idx_ff + 1'b1;
            if (idx_ff == IDX_LAST) begin
               rsp_valid_in   = 1'b1;
               char_valid_in  = 1'b0;
               char_code_in   = '0;
               rsp_queued_in  = queued_in;
               rsp_dropped_in = dropped_in;
               fill_in        = fill_of(wp_in, rp_ff);
               state_in       = ST_IDLE;
            end
         end
         ST_READ: begin
            // RAM data for the popped entry is ready now
            rp_in          = rp_inc;
            rsp_valid_in   = 1'b1;
            char_valid_in  = 1'b1;
            char_code_in   = rd_data;
            rsp_queued_in  = '0;
            rsp_dropped_in = '0;
            fill_in        = fill_of(wp_ff, rp_inc);
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rp_ff        <= '0;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      for (int i = 0; i < KEYS; i++) begin
         keys_ff[i] <= keys_in[i];
      end
      shift_ff       <= shift_in;
      queued_ff      <= queued_in;
      dropped_ff     <= dropped_in;
      char_valid_ff  <= char_valid_in;
      char_code_ff   <= char_code_in;
      rsp_queued_ff  <= rsp_queued_in;
      rsp_dropped_ff <= rsp_dropped_in;
      fill_ff        <= fill_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_char_valid    = char_valid_ff;
   assign rsp_char_code     = char_code_ff;
   assign rsp_queued_count  = rsp_queued_ff;
   assign rsp_dropped_count = rsp_dropped_ff;
   assign rsp_fill_level    = fill_ff;

   // checks
   `ASSERT_PROP(a_accept_leads_on, clock, reset, accept |=> (busy || rsp_valid), "accepted command neither busy nor answered")
   `ASSERT_NEVER(a_write_when_full, clock, reset, wr_en && ring_full, "ring written while full")
   `ASSERT_NEVER(a_pop_with_counts, clock, reset, rsp_valid && rsp_char_valid && (rsp_queued_count != '0 || rsp_dropped_count != '0), "pop result carries report counts")
   `ASSERT_PROP(a_report_count_bound, clock, reset, rsp_valid |-> ((4'(rsp_queued_count) + 4'(rsp_dropped_count)) <= 4'(KEYS)), "more characters counted than key slots")

endmodule

`default_nettype wire

[rtl/hidkb_ram.sv]
// Simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module hidkb_ram #(
   parameter int DEPTH  = 64,
   parameter int WIDTH  = 7,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire
